[hdl/lzca_pkg.sv]
// ----------------------------------------------------------------------------
// lzca_pkg
// Shared constants and types for the LED zone color averager.
// ----------------------------------------------------------------------------
package lzca_pkg;

  localparam int MAX_LEDS = 512;
  localparam int MAX_DIM  = 4096;

  localparam int BIN_W   = $clog2(MAX_LEDS);
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 24;
  localparam int CFG_W   = 13;

  typedef enum logic [2:0] {
    REG_ZONE_TOP        = 3'd0,
    REG_ZONE_HEIGHT     = 3'd1,
    REG_ZONE_LEFT       = 3'd2,
    REG_ZONE_WIDTH      = 3'd3,
    REG_LED_COUNT       = 3'd4,
    REG_FIRST_SLOT      = 3'd5,
    REG_BASE_BRIGHTNESS = 3'd6,
    REG_REVERSE_ORDER   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
  } acc_t;

  localparam logic [7:0] DIM_QUARTER = 8'd50;
  localparam logic [7:0] DIM_HALF    = 8'd100;

endpackage

[hdl/led_zone_color_averager.sv]
// ----------------------------------------------------------------------------
// led_zone_color_averager
// Sums zone pixels into LED column bins and reads out per-bin averages.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per pixel (mode 0) or
// per readout request (mode 1). Results leave on out_valid/out_ready, one word
// per readout of a bin below the LED count; pixels give no result.
// Config channel (cfg_valid/cfg_ready) is always ready; write only when idle.
// After reset a clearing pass zeroes the 512-entry bin memory; in_ready stays
// low meanwhile.
// A pixel outside the zone only advances the row and column counters. A pixel
// inside runs one multiply, 32 steps of the shared restoring divider for the
// bin, a memory read and a read-modify-write.
// A readout: memory read, then for an empty bin zero averages, else three
// 32-step divisions on the same divider; then the result load.
// The result sits in an output register; new words are accepted while it
// waits. Readouts hold while the register is full and out_ready is low.
// ----------------------------------------------------------------------------
module led_zone_color_averager
  import lzca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic                in_end_of_line,
  input  logic                in_end_of_frame,
  input  logic [8:0]          in_bin_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          out_slot,
  output logic [7:0]          out_avg_red,
  output logic [7:0]          out_avg_green,
  output logic [7:0]          out_avg_blue,
  output logic [7:0]          out_led_brightness,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_DIV, ST_BIN, ST_ACC, ST_LOAD, ST_RESULT
  } state_t;

  state_t state_r;

  logic [11:0] zone_top_r, zone_height_r, zone_left_r;
  logic [12:0] zone_width_r;
  logic [9:0]  led_count_r;
  logic [8:0]  first_slot_r;
  logic [7:0]  base_brightness_r;
  logic        reverse_order_r;

  logic [COORD_W-1:0] row_r, col_r;
  logic [BIN_W-1:0]   clr_cnt_r, bin_r;
  logic [11:0]        off_r;
  logic [7:0]         pr_r, pg_r, pb_r;
  logic               rdo_r;
  logic [1:0]         ch_r;
  logic [SUM_W-1:0]   sum_r [3];
  logic [7:0]         avg_r [3];
  logic [SUM_W-1:0]   dq_r;
  logic [CNT_W-1:0]   div_r, rem_r;
  logic [4:0]         step_r;

  logic       out_valid_r;
  logic [9:0] out_slot_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r, out_bri_r;
  logic       out_load;

  acc_t             mem [MAX_LEDS];
  acc_t             mem_q_r, mem_wd;
  logic             mem_we;
  logic [BIN_W-1:0] mem_wa, mem_ra;

  logic [9:0]  n_eff;
  logic [12:0] zw_eff;
  logic        in_zone, acc_pix, acc_rdo;
  logic [21:0] prod;
  logic [CNT_W:0] shifted;
  logic        ge;
  logic [CNT_W-1:0] rem_nxt;
  logic [SUM_W-1:0] q_nxt;
  logic [7:0]  q_sat, mx, bri;
  logic [10:0] slot_sum;
  logic [SUM_W:0] sr, sg, sb;
  logic [CNT_W:0] sc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign acc_pix   = in_valid && in_ready && !in_mode;
  assign acc_rdo   = in_valid && in_ready && in_mode;
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || out_ready);

  assign n_eff  = (led_count_r == 10'd0) ? 10'd1 :
                  (led_count_r > 10'(MAX_LEDS)) ? 10'(MAX_LEDS) : led_count_r;
  assign zw_eff = (zone_width_r == 13'd0) ? 13'd1 : zone_width_r;

  assign in_zone = (row_r >= zone_top_r) &&
                   ({1'b0, row_r} <= {1'b0, zone_top_r} + {1'b0, zone_height_r}) &&
                   (col_r >= zone_left_r) &&
                   ({2'b0, col_r} <= {2'b0, zone_left_r} + {1'b0, zw_eff});

  assign prod    = off_r * n_eff;
  assign shifted = {rem_r, dq_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign rem_nxt = ge ? CNT_W'(shifted - {1'b0, div_r}) : shifted[CNT_W-1:0];
  assign q_nxt   = {dq_r[SUM_W-2:0], ge};
  assign q_sat   = (q_nxt > 32'd255) ? 8'd255 : q_nxt[7:0];

  assign mx = (avg_r[0] >= avg_r[1] && avg_r[0] >= avg_r[2]) ? avg_r[0] :
              (avg_r[1] >= avg_r[2]) ? avg_r[1] : avg_r[2];
  always_comb begin
    priority if (mx < DIM_QUARTER) begin
      bri = base_brightness_r >> 2;
    end else if (mx < DIM_HALF) begin
      bri = base_brightness_r >> 1;
    end else begin
      bri = base_brightness_r;
    end
  end
  assign slot_sum = reverse_order_r ?
                    11'(first_slot_r) + 11'(n_eff) - 11'd1 - 11'(bin_r) :
                    11'(first_slot_r) + 11'(bin_r);

  assign sr = {1'b0, mem_q_r.red}   + (SUM_W+1)'(pr_r);
  assign sg = {1'b0, mem_q_r.green} + (SUM_W+1)'(pg_r);
  assign sb = {1'b0, mem_q_r.blue}  + (SUM_W+1)'(pb_r);
  assign sc = {1'b0, mem_q_r.count} + (CNT_W+1)'(1);

  assign mem_ra = (state_r == ST_IDLE) ? in_bin_index : bin_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = bin_r;
    mem_wd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
      end
      ST_ACC: begin
        mem_we       = 1'b1;
        mem_wd.red   = sr[SUM_W] ? '1 : sr[SUM_W-1:0];
        mem_wd.green = sg[SUM_W] ? '1 : sg[SUM_W-1:0];
        mem_wd.blue  = sb[SUM_W] ? '1 : sb[SUM_W-1:0];
        mem_wd.count = sc[CNT_W] ? '1 : sc[CNT_W-1:0];
      end
      ST_LOAD: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_CLEAR;
      clr_cnt_r         <= '0;
      row_r             <= '0;
      col_r             <= '0;
      zone_top_r        <= '0;
      zone_height_r     <= '0;
      zone_left_r       <= '0;
      zone_width_r      <= 13'd1;
      led_count_r       <= 10'd1;
      first_slot_r      <= '0;
      base_brightness_r <= 8'd60;
      reverse_order_r   <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ZONE_TOP:        zone_top_r        <= cfg_data[11:0];
          REG_ZONE_HEIGHT:     zone_height_r     <= cfg_data[11:0];
          REG_ZONE_LEFT:       zone_left_r       <= cfg_data[11:0];
          REG_ZONE_WIDTH:      zone_width_r      <= cfg_data;
          REG_LED_COUNT:       led_count_r       <= cfg_data[9:0];
          REG_FIRST_SLOT:      first_slot_r      <= cfg_data[8:0];
          REG_BASE_BRIGHTNESS: base_brightness_r <= cfg_data[7:0];
          REG_REVERSE_ORDER:   reverse_order_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_pix) begin
            pr_r  <= in_red;
            pg_r  <= in_green;
            pb_r  <= in_blue;
            off_r <= col_r - zone_left_r;
            rdo_r <= 1'b0;
            if (in_zone) begin
              state_r <= ST_MUL;
            end
            if (in_end_of_frame) begin
              row_r <= '0;
              col_r <= '0;
            end else if (in_end_of_line) begin
              col_r <= '0;
              if (!(&row_r)) row_r <= row_r + 1'b1;
            end else begin
              if (!(&col_r)) col_r <= col_r + 1'b1;
            end
          end else if (acc_rdo) begin
            rdo_r <= 1'b1;
            bin_r <= in_bin_index;
            if (10'(in_bin_index) < n_eff) begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_MUL: begin
          dq_r    <= {10'd0, prod};
          div_r   <= {11'd0, zw_eff};
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (!(&step_r)) begin
            dq_r  <= q_nxt;
            rem_r <= rem_nxt;
          end else if (!rdo_r) begin
            bin_r   <= (q_nxt >= 32'(n_eff)) ? BIN_W'(n_eff - 10'd1) : q_nxt[BIN_W-1:0];
            state_r <= ST_BIN;
          end else begin
            avg_r[ch_r] <= q_sat;
            rem_r       <= '0;
            ch_r        <= ch_r + 1'b1;
            if (ch_r == 2'd2) begin
              state_r <= ST_RESULT;
            end else begin
              dq_r <= sum_r[ch_r + 2'd1];
            end
          end
        end
        ST_BIN: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= ST_IDLE;
        end
        ST_LOAD: begin
          sum_r[0] <= mem_q_r.red;
          sum_r[1] <= mem_q_r.green;
          sum_r[2] <= mem_q_r.blue;
          dq_r     <= mem_q_r.red;
          div_r    <= mem_q_r.count;
          rem_r    <= '0;
          step_r   <= '0;
          ch_r     <= '0;
          if (mem_q_r.count == '0) begin
            avg_r[0] <= '0;
            avg_r[1] <= '0;
            avg_r[2] <= '0;
            state_r  <= ST_RESULT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            out_slot_r  <= slot_sum[9:0];
            out_red_r   <= avg_r[0];
            out_green_r <= avg_r[1];
            out_blue_r  <= avg_r[2];
            out_bri_r   <= bri;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_avg_red        = out_red_r;
  assign out_avg_green      = out_green_r;
  assign out_avg_blue       = out_blue_r;
  assign out_led_brightness = out_bri_r;

endmodule
